// ----- rtl/sau_pkg.sv -----
`default_nettype none
package sau_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int DATA_W      = 32;
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CMD_W       = 3;
    localparam int STATUS_W    = 2;
    localparam int DIV_CNT_W   = $clog2(DATA_W);

    // Stream payload layout, lowest field first, padded to whole bytes.
    localparam int IN_BITS   = CMD_W + DATA_W;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS  = STATUS_W + DATA_W + DEPTH_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int OUT_TOP_LSB   = STATUS_W;
    localparam int OUT_DEPTH_LSB = STATUS_W + DATA_W;

    localparam logic [CMD_W-1:0] CMD_NOP  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SWAP = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ADD  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SUB  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_DIV  = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SHORT   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DIVZERO = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the incoming request
        logic exec;      // carry out the command, or set up the divider for div
        logic div_step;  // one quotient bit
        logic div_pop;   // write the quotient back and pop
        logic refill;    // reload the second entry from the memory
        logic deliver;   // load the result register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic err;          // command rejected, stack left unchanged
        logic is_div;
        logic is_pop;       // add or sub
        logic refill_need;  // a pop leaves two or more entries
        logic div_last;     // final quotient bit is being produced
    } t_dp_stat;

endpackage
`default_nettype wire

// ----- rtl/sau_ctrl.sv -----
`default_nettype none
module sau_ctrl
    import sau_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_req_valid,
    output logic          o_req_ready,
    output logic          o_res_valid,
    input  wire logic     i_res_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_DIV    = 3'd2;
    localparam logic [2:0] S_DIVFIN = 3'd3;
    localparam logic [2:0] S_REFILL = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0] r_state, n_state;
    logic       r_res_valid, n_res_valid;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_stat.err) begin
                    n_state = S_DONE;
                end else if (i_stat.is_div) begin
                    n_state = S_DIV;
                end else if (i_stat.is_pop && i_stat.refill_need) begin
                    n_state = S_REFILL;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_DIVFIN;
                end
            end
            S_DIVFIN: begin
                o_cmd.div_pop = 1'b1;
                n_state = i_stat.refill_need ? S_REFILL : S_DONE;
            end
            S_REFILL: begin
                o_cmd.refill = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (!r_res_valid || i_res_ready) begin
                    o_cmd.deliver = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_res_valid = (r_res_valid && !i_res_ready) || o_cmd.deliver;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
        end
    end

    assign o_res_valid = r_res_valid;

endmodule
`default_nettype wire

// ----- rtl/sau_datapath.sv -----
`default_nettype none
module sau_datapath
    import sau_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_dp_cmd                i_cmd,
    input  wire logic [CMD_W-1:0]       i_req_cmd,
    input  wire logic [DATA_W-1:0]      i_req_value,
    output t_dp_stat                    o_stat,
    output logic [STATUS_W-1:0]         o_res_status,
    output logic [DATA_W-1:0]           o_res_top,
    output logic [DEPTH_W-1:0]          o_res_depth
);

    // The top two entries live in registers; deeper entries live in the memory,
    // entry k of the stack at address k.
    logic [DATA_W-1:0]   r_mem [STACK_DEPTH];
    logic [DATA_W-1:0]   r_rd_data;

    logic [CMD_W-1:0]    r_cmd;
    logic [DATA_W-1:0]   r_val;
    logic [DATA_W-1:0]   r_top;
    logic [DATA_W-1:0]   r_second;
    logic [DEPTH_W-1:0]  r_depth, n_depth;
    logic [STATUS_W-1:0] r_status;

    logic [DATA_W-1:0]    r_rem;
    logic [DATA_W-1:0]    r_quo;
    logic [DATA_W-1:0]    r_dvs;
    logic                 r_neg;
    logic [DIV_CNT_W-1:0] r_cnt;

    logic [STATUS_W-1:0] st;
    logic                depth_ge2;
    logic                full;
    logic                ok_exec;
    logic [DEPTH_W-1:0]  wr_ptr;
    logic [DEPTH_W-1:0]  rd_ptr;
    logic [DATA_W:0]     rem_sh;
    logic [DATA_W+1:0]   diff;
    logic [DATA_W-1:0]   quo_signed;

    assign depth_ge2 = (r_depth >= DEPTH_W'(2));
    assign full      = (r_depth == DEPTH_W'(STACK_DEPTH));
    assign wr_ptr    = r_depth - DEPTH_W'(2);
    assign rd_ptr    = r_depth - DEPTH_W'(3);

    always_comb begin
        st = ST_OK;
        if (r_cmd == CMD_PUSH) begin
            st = full ? ST_FULL : ST_OK;
        end else if (r_cmd inside {CMD_SWAP, CMD_ADD, CMD_SUB, CMD_DIV}) begin
            if (!depth_ge2) begin
                st = ST_SHORT;
            end else if (r_cmd == CMD_DIV && r_top == '0) begin
                st = ST_DIVZERO;
            end
        end
    end

    assign ok_exec = i_cmd.exec && (st == ST_OK);

    always_comb begin
        o_stat.err         = (st != ST_OK);
        o_stat.is_div      = (r_cmd == CMD_DIV);
        o_stat.is_pop      = (r_cmd == CMD_ADD) || (r_cmd == CMD_SUB);
        o_stat.refill_need = (r_depth >= DEPTH_W'(3));
        o_stat.div_last    = (r_cnt == '1);
    end

    // Restoring division on magnitudes, one quotient bit per step.
    assign rem_sh     = {r_rem, r_quo[DATA_W-1]};
    assign diff       = {1'b0, rem_sh} - {2'b00, r_dvs};
    assign quo_signed = r_neg ? (DATA_W'(0) - r_quo) : r_quo;

    always_comb begin
        n_depth = r_depth;
        if (ok_exec && r_cmd == CMD_PUSH) begin
            n_depth = r_depth + DEPTH_W'(1);
        end else if ((ok_exec && (r_cmd == CMD_ADD || r_cmd == CMD_SUB)) || i_cmd.div_pop) begin
            n_depth = r_depth - DEPTH_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
        end else begin
            r_depth <= n_depth;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd <= i_req_cmd;
            r_val <= i_req_value;
        end
        if (i_cmd.exec) begin
            r_status <= st;
        end
        if (ok_exec) begin
            case (r_cmd)
                CMD_PUSH: begin
                    r_second <= r_top;
                    r_top    <= r_val;
                end
                CMD_SWAP: begin
                    r_second <= r_top;
                    r_top    <= r_second;
                end
                CMD_ADD: begin
                    r_top <= r_second + r_top;
                end
                CMD_SUB: begin
                    r_top <= r_second - r_top;
                end
                CMD_DIV: begin
                    r_rem <= '0;
                    r_quo <= r_second[DATA_W-1] ? (DATA_W'(0) - r_second) : r_second;
                    r_dvs <= r_top[DATA_W-1] ? (DATA_W'(0) - r_top) : r_top;
                    r_neg <= r_second[DATA_W-1] ^ r_top[DATA_W-1];
                    r_cnt <= '0;
                end
                default: begin
                end
            endcase
        end
        if (i_cmd.div_step) begin
            r_cnt <= r_cnt + DIV_CNT_W'(1);
            if (!diff[DATA_W+1]) begin
                r_rem <= diff[DATA_W-1:0];
                r_quo <= {r_quo[DATA_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[DATA_W-1:0];
                r_quo <= {r_quo[DATA_W-2:0], 1'b0};
            end
        end
        if (i_cmd.div_pop) begin
            r_top <= quo_signed;
        end
        if (i_cmd.refill) begin
            r_second <= r_rd_data;
        end
    end

    // Stack memory: the old second entry spills on a push; the entry below the
    // second is read every cycle so that it is ready when a pop needs it.
    always_ff @(posedge i_clk) begin
        if (ok_exec && r_cmd == CMD_PUSH && depth_ge2) begin
            r_mem[wr_ptr[ADDR_W-1:0]] <= r_second;
        end
        r_rd_data <= r_mem[rd_ptr[ADDR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.deliver) begin
            o_res_status <= r_status;
            o_res_top    <= (r_depth != '0) ? r_top : '0;
            o_res_depth  <= r_depth;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/stack_arith_unit.sv -----
// Sequence: an accepted request is executed; div then runs the divider (one quotient bit per
// cycle) and writes the quotient back with a pop. A pop that leaves two or more entries then
// refills the second register from the memory. Nop, push, swap and rejected commands go
// straight to the result. Add, sub and div skip the refill if the pop leaves one entry.
// A new request is taken only after the last result loads, which m_axis_tready stalls delay.
// Reset (i_rst_n low, synchronous) empties the stack and drops any pending result.
`default_nettype none
module stack_arith_unit
    import sau_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // s_axis_tdata: cmd [2:0], push_value [34:3], zero pad above
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // m_axis_tdata: status [1:0], top_value [33:2], stack_depth [40:34], zero pad above
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

    // The controller sequences each request through execute, divide and refill
    // steps; the datapath holds the stack, the divider and the result register.
    t_dp_cmd             dp_cmd;
    t_dp_stat            dp_stat;
    logic [STATUS_W-1:0] res_status;
    logic [DATA_W-1:0]   res_top;
    logic [DEPTH_W-1:0]  res_depth;

    sau_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    sau_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .i_req_cmd    (s_axis_tdata[CMD_W-1:0]),
        .i_req_value  (s_axis_tdata[CMD_W +: DATA_W]),
        .o_stat       (dp_stat),
        .o_res_status (res_status),
        .o_res_top    (res_top),
        .o_res_depth  (res_depth)
    );

    // Pack the result fields, lowest field first, with zero padding on top.
    assign m_axis_tdata = OUT_TDATA_W'({res_depth, res_top, res_status});

endmodule
`default_nettype wire

// ----- rtl/sau_checker.sv -----
`default_nettype none
module sau_checker
    import sau_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   s_axis_tvalid,
    input wire logic                   s_axis_tready,
    input wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic [STATUS_W-1:0] out_status;
    logic [DATA_W-1:0]   out_top;
    logic [DEPTH_W-1:0]  out_depth;

    assign out_status = m_axis_tdata[STATUS_W-1:0];
    assign out_top    = m_axis_tdata[OUT_TOP_LSB +: DATA_W];
    assign out_depth  = m_axis_tdata[OUT_DEPTH_LSB +: DEPTH_W];

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_req_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata))
        else $error("waiting request changed");

    a_full_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && out_status == ST_FULL |-> out_depth == DEPTH_W'(STACK_DEPTH))
        else $error("full status without a full stack");

    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && out_depth == '0 |-> out_top == '0 && out_status != ST_DIVZERO)
        else $error("empty stack with nonzero top or divide status");

endmodule

bind stack_arith_unit sau_checker u_sau_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import sau_pkg::*;

    localparam int RESET_CYCLES    = 7;
    localparam int RANDOM_REQUESTS = 1650;
    // Longest quiet stretch in a correct run is one long sender gap, a divide
    // and a chain of long receiver stalls; this is several times that.
    localparam int IDLE_LIMIT      = 3000;
    // Wait at the end for longer than a divide takes to answer its request.
    localparam int DRAIN_CYCLES    = 48;

    // Command codes the block treats as no operation.
    localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   top_value;
        logic [DEPTH_W-1:0]  stack_depth;
    } t_stack_report;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [DATA_W-1:0] push_value;
        logic              has_report;  // report below is the expected answer
        t_stack_report     report;
    } t_probe_row;

    // Opening sequence: rejections on an empty and a one-entry stack, wrapping add, the most negative
    // value divided by minus one, zero divisor, spare commands, truncating divides.
    localparam int PROBE_COUNT = 25;
    localparam t_probe_row PROBE_ROWS [PROBE_COUNT] = '{
        '{CMD_NOP,    32'h0000_0000, 1'b1, '{ST_OK,      32'h0000_0000, 7'd0}},
        '{CMD_SWAP,   32'h0000_0000, 1'b1, '{ST_SHORT,   32'h0000_0000, 7'd0}},
        '{CMD_ADD,    32'h0000_0000, 1'b1, '{ST_SHORT,   32'h0000_0000, 7'd0}},
        '{CMD_PUSH,   32'h7FFF_FFFF, 1'b1, '{ST_OK,      32'h7FFF_FFFF, 7'd1}},
        '{CMD_SUB,    32'h0000_0000, 1'b1, '{ST_SHORT,   32'h7FFF_FFFF, 7'd1}},
        '{CMD_DIV,    32'h0000_0000, 1'b1, '{ST_SHORT,   32'h7FFF_FFFF, 7'd1}},
        '{CMD_PUSH,   32'h0000_0001, 1'b1, '{ST_OK,      32'h0000_0001, 7'd2}},
        '{CMD_ADD,    32'hFFFF_FFFF, 1'b1, '{ST_OK,      32'h8000_0000, 7'd1}},
        '{CMD_PUSH,   32'hFFFF_FFFF, 1'b1, '{ST_OK,      32'hFFFF_FFFF, 7'd2}},
        '{CMD_DIV,    32'h0000_0000, 1'b1, '{ST_OK,      32'h8000_0000, 7'd1}},
        '{CMD_PUSH,   32'h0000_0000, 1'b1, '{ST_OK,      32'h0000_0000, 7'd2}},
        '{CMD_DIV,    32'h0000_0000, 1'b1, '{ST_DIVZERO, 32'h0000_0000, 7'd2}},
        '{CMD_SWAP,   32'h0000_0000, 1'b0, '0},
        '{CMD_SUB,    32'h0000_0000, 1'b0, '0},
        '{CMD_SPARE6, 32'hFFFF_FFFF, 1'b0, '0},
        '{CMD_SPARE7, 32'h5555_5555, 1'b0, '0},
        '{CMD_PUSH,   32'hFFFF_FFF9, 1'b0, '0},
        '{CMD_PUSH,   32'h0000_0002, 1'b0, '0},
        '{CMD_DIV,    32'h0000_0000, 1'b0, '0},
        '{CMD_PUSH,   32'h8000_0000, 1'b0, '0},
        '{CMD_SUB,    32'h0000_0000, 1'b0, '0},
        '{CMD_NOP,    32'hAAAA_AAAA, 1'b0, '0},
        '{CMD_PUSH,   32'h0000_0007, 1'b0, '0},
        '{CMD_PUSH,   32'hFFFF_FFFE, 1'b0, '0},
        '{CMD_DIV,    32'h0000_0000, 1'b0, '0}
    };

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // s_axis_tdata: cmd [2:0], push_value [34:3], zero pad above
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // m_axis_tdata: status [1:0], top_value [33:2], stack_depth [40:34], zero pad above
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // Shadow copy of the operand stack, updated when a request is accepted.
    logic [DATA_W-1:0] shadow_stack [STACK_DEPTH];
    int                shadow_depth = 0;

    t_stack_report pending_reports [$];
    int            mismatch_count = 0;
    int            idle_cycles = 0;
    int            sink_hold = 0;
    bit            calm = 1'b0;  // no new gaps or stalls on either side while set

    stack_arith_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 i_clk = ~i_clk;

    // Applies one command to the shadow stack and returns the report it yields.
    function automatic t_stack_report run_stack_cmd(input logic [CMD_W-1:0] cmd,
                                                    input logic [DATA_W-1:0] value);
        t_stack_report     rep;
        logic [DATA_W-1:0] top_e;
        logic [DATA_W-1:0] next_e;
        logic [DATA_W-1:0] num_mag;
        logic [DATA_W-1:0] den_mag;
        logic [DATA_W-1:0] quo_mag;
        rep = '0;
        rep.status = ST_OK;
        case (cmd)
            CMD_PUSH: begin
                if (shadow_depth >= STACK_DEPTH) begin
                    rep.status = ST_FULL;
                end else begin
                    shadow_stack[shadow_depth] = value;
                    shadow_depth++;
                end
            end
            CMD_SWAP, CMD_ADD, CMD_SUB, CMD_DIV: begin
                if (shadow_depth < 2) begin
                    rep.status = ST_SHORT;
                end else begin
                    top_e  = shadow_stack[shadow_depth - 1];
                    next_e = shadow_stack[shadow_depth - 2];
                    case (cmd)
                        CMD_SWAP: begin
                            shadow_stack[shadow_depth - 1] = next_e;
                            shadow_stack[shadow_depth - 2] = top_e;
                        end
                        CMD_ADD: begin
                            shadow_stack[shadow_depth - 2] = next_e + top_e;
                            shadow_depth--;
                        end
                        CMD_SUB: begin
                            shadow_stack[shadow_depth - 2] = next_e - top_e;
                            shadow_depth--;
                        end
                        default: begin
                            if (top_e == '0) begin
                                rep.status = ST_DIVZERO;
                            end else begin
                                // Divide magnitudes, then restore the sign, so the
                                // quotient truncates toward zero and wraps cleanly.
                                num_mag = next_e[DATA_W-1] ? -next_e : next_e;
                                den_mag = top_e[DATA_W-1] ? -top_e : top_e;
                                quo_mag = num_mag / den_mag;
                                shadow_stack[shadow_depth - 2] =
                                    (next_e[DATA_W-1] ^ top_e[DATA_W-1]) ? -quo_mag : quo_mag;
                                shadow_depth--;
                            end
                        end
                    endcase
                end
            end
            default: ;
        endcase
        rep.top_value   = (shadow_depth > 0) ? shadow_stack[shadow_depth - 1] : '0;
        rep.stack_depth = DEPTH_W'(shadow_depth);
        return rep;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        logic [DATA_W-1:0] r;
        r = $urandom;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0:       return 32'h0000_0000;
                    1:       return 32'h0000_0001;
                    2:       return 32'hFFFF_FFFF;
                    3:       return 32'h8000_0000;
                    default: return 32'h7FFF_FFFF;
                endcase
            end
            1, 2, 3: return DATA_W'($urandom_range(0, 40)) - 32'd20;
            4, 5:    return {{16{r[15]}}, r[15:0]};
            default: return r;
        endcase
    endfunction

    // Keeps the stack fed when it is nearly empty, but still lets some
    // two-operand commands hit a short stack.
    function automatic logic [CMD_W-1:0] pick_cmd();
        int r;
        r = $urandom_range(0, 99);
        if (shadow_depth < 2 && $urandom_range(0, 3) != 0) return CMD_PUSH;
        if (r < 4)  return CMD_NOP;
        if (r < 6)  return $urandom_range(0, 1) ? CMD_SPARE6 : CMD_SPARE7;
        if (r < 36) return CMD_PUSH;
        if (r < 46) return CMD_SWAP;
        if (r < 61) return CMD_ADD;
        if (r < 76) return CMD_SUB;
        return CMD_DIV;
    endfunction

    // Offers one request and holds it until the block takes it. The valid line
    // is only lowered when a gap follows, so it never toggles within one step.
    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] value,
                                input logic has_report, input t_stack_report report);
        int            gap;
        t_stack_report predicted;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= IN_TDATA_W'({$urandom, $urandom});
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'({value, cmd});
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = run_stack_cmd(cmd, value);
        pending_reports.push_back(has_report ? report : predicted);
    endtask

    // Result side back-pressure.
    always @(posedge i_clk) begin
        int stall;
        if (sink_hold > 0) begin
            sink_hold     <= sink_hold - 1;
            m_axis_tready <= 1'b0;
        end else begin
            stall = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
            if (stall > 0) begin
                sink_hold     <= stall - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : check_reports
        t_stack_report       want;
        logic [STATUS_W-1:0] got_status;
        logic [DATA_W-1:0]   got_top;
        logic [DEPTH_W-1:0]  got_depth;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_status = m_axis_tdata[OUT_TOP_LSB-1:0];
            got_top    = m_axis_tdata[OUT_TOP_LSB +: DATA_W];
            got_depth  = m_axis_tdata[OUT_DEPTH_LSB +: DEPTH_W];
            if (pending_reports.size() == 0) begin
                $error("unexpected result: status %0d, top_value %h, stack_depth %0d",
                       got_status, got_top, got_depth);
                mismatch_count++;
            end else begin
                want = pending_reports.pop_front();
                if (got_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got_status);
                    mismatch_count++;
                end
                if (got_top !== want.top_value) begin
                    $error("top_value: expected %h, got %h", want.top_value, got_top);
                    mismatch_count++;
                end
                if (got_depth !== want.stack_depth) begin
                    $error("stack_depth: expected %0d, got %0d", want.stack_depth, got_depth);
                    mismatch_count++;
                end
            end
        end
    end

    // Ends a hung run: counts cycles in which neither side completes a handshake.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int               issued;
        bit               fill_run;
        logic [CMD_W-1:0] cmd;
        issued = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < PROBE_COUNT; i++) begin
            send_request(PROBE_ROWS[i].cmd, PROBE_ROWS[i].push_value,
                         PROBE_ROWS[i].has_report, PROBE_ROWS[i].report);
        end

        while (issued < RANDOM_REQUESTS) begin
            if ($urandom_range(0, 59) == 0) calm = !calm;
            // The first random stretch, and a few later ones, fill the stack to
            // the top and then push into the full stack.
            fill_run = (issued == 0) || ($urandom_range(0, 249) == 0);
            if (fill_run) begin
                while (shadow_depth < STACK_DEPTH) begin
                    send_request(CMD_PUSH, pick_value(), 1'b0, '0);
                    issued++;
                end
                repeat ($urandom_range(1, 3)) begin
                    send_request(CMD_PUSH, pick_value(), 1'b0, '0);
                    issued++;
                end
            end else begin
                cmd = pick_cmd();
                send_request(cmd, pick_value(), 1'b0, '0);
                issued++;
            end
        end
        s_axis_tvalid <= 1'b0;

        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/sau_pkg.sv
rtl/sau_ctrl.sv
rtl/sau_datapath.sv
rtl/stack_arith_unit.sv
rtl/sau_checker.sv
sim/tb_top.sv
